// ----- sv/qea_pkg.sv -----
// Package for the quadric error accumulator.
// Holds widths, function codes, micro-op codes and the step sequencer tables.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qea_pkg;

    // Configuration of the block
    localparam int MAX_TRIANGLES = 16;
    localparam int COORD_WIDTH   = 8;

    // Port widths
    localparam int FUNC_W  = 2;
    localparam int PORT_W  = 8;
    localparam int ERR_W   = 62;
    localparam int CNT_W   = 5;

    // Internal datapath widths
    localparam int U_W     = COORD_WIDTH + 1;      // edge vector component
    localparam int N_W     = 2 * U_W + 1;          // normal component
    localparam int D_W     = 28;                   // plane offset
    localparam int M_W     = 2 * COORD_WIDTH;      // point monomial
    localparam int COEF_W  = 64;
    localparam int NCOEF   = 10;
    localparam int HALF_W  = COEF_W / 2;
    localparam int MUL_A_W = HALF_W + 1;
    localparam int MUL_B_W = 29;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Sequencer
    localparam int STEP_W     = 5;
    localparam int ADD_STEPS  = 19;
    localparam int MONO_STEPS = 6;
    localparam int EVAL_STEPS = MONO_STEPS + 2 * NCOEF;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL  = 2'd2;

    // Coefficient slots
    typedef enum logic [3:0] {
        K_A2, K_B2, K_C2, K_D2, K_AB, K_AC, K_AD, K_BC, K_BD, K_CD
    } coef_idx_t;

    // Micro-ops of the shared multiplier
    typedef enum logic [4:0] {
        OP_UYWZ, OP_UZWY, OP_UZWX, OP_UXWZ, OP_UXWY, OP_UYWX,
        OP_DAX, OP_DBY, OP_DCZ,
        OP_QAA, OP_QBB, OP_QCC, OP_QAB, OP_QAC, OP_QBC,
        OP_QDD, OP_QAD, OP_QBD, OP_QCD,
        OP_MXX, OP_MYY, OP_MZZ, OP_MXY, OP_MXZ, OP_MYZ,
        OP_ELO, OP_EHI
    } op_t;

    // Sequencer state, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // Micro-op issued at a given step
    function automatic op_t seq_op(input logic is_eval, input logic [STEP_W-1:0] step);
        op_t op;
        op = OP_QCD;
        if (!is_eval)
        begin
            case (step)
                5'd0:    op = OP_UYWZ;
                5'd1:    op = OP_UZWY;
                5'd2:    op = OP_UZWX;
                5'd3:    op = OP_UXWZ;
                5'd4:    op = OP_UXWY;
                5'd5:    op = OP_UYWX;
                5'd6:    op = OP_DAX;
                5'd7:    op = OP_DBY;
                5'd8:    op = OP_DCZ;
                5'd9:    op = OP_QAA;
                5'd10:   op = OP_QBB;
                5'd11:   op = OP_QCC;
                5'd12:   op = OP_QAB;
                5'd13:   op = OP_QAC;
                5'd14:   op = OP_QBC;
                5'd15:   op = OP_QDD;
                5'd16:   op = OP_QAD;
                5'd17:   op = OP_QBD;
                default: op = OP_QCD;
            endcase
        end
        else
        begin
            case (step)
                5'd0:    op = OP_MXX;
                5'd1:    op = OP_MYY;
                5'd2:    op = OP_MZZ;
                5'd3:    op = OP_MXY;
                5'd4:    op = OP_MXZ;
                5'd5:    op = OP_MYZ;
                default: op = step[0] ? OP_EHI : OP_ELO;
            endcase
        end
        return op;
    endfunction

    // Coefficient slot touched at a given step
    function automatic coef_idx_t seq_coef(input logic is_eval,
                                           input logic [STEP_W-1:0] step);
        coef_idx_t k;
        logic [STEP_W-1:0] rel;
        rel = step - STEP_W'(MONO_STEPS);
        k = K_A2;
        if (is_eval)
        begin
            k = coef_idx_t'(rel[4:1]);
        end
        else
        begin
            case (step)
                5'd9:    k = K_A2;
                5'd10:   k = K_B2;
                5'd11:   k = K_C2;
                5'd12:   k = K_AB;
                5'd13:   k = K_AC;
                5'd14:   k = K_BC;
                5'd15:   k = K_D2;
                5'd16:   k = K_AD;
                5'd17:   k = K_BD;
                5'd18:   k = K_CD;
                default: k = K_A2;
            endcase
        end
        return k;
    endfunction

endpackage

// ----- sv/qea_mul.sv -----
// Shared signed multiplier of the quadric error accumulator, product registered.
// Depends on qea_pkg for operand and product widths.
`timescale 1ns / 1ps

module qea_mul
    import qea_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // One product per cycle while en is high
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- sv/quadric_error_accumulator_top.sv -----
// Top level of the quadric error accumulator: sequencer, coefficient store, output register.
// Depends on qea_pkg and qea_mul.
`timescale 1ns / 1ps

// One item is in work at a time; item_stall is high from acceptance until the
// result is loaded into the output register, which then waits on result_stall
// while the next item can already be taken. Clear, unused codes and a refused
// add (store holds MAX_TRIANGLES triangles) skip the multiplier. An add and
// an evaluate send all products one per cycle through a single 33 x 29 bit
// multiplier (9 for the plane, 10 coefficient products; or 6 point monomials
// and two 32-bit halves for each of the ten coefficients), then a write-back
// and the load of the result.
module quadric_error_accumulator_top
    import qea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [PORT_W-1:0] vertex0_x,
    input  logic signed [PORT_W-1:0] vertex0_y,
    input  logic signed [PORT_W-1:0] vertex0_z,
    input  logic signed [PORT_W-1:0] vertex1_x,
    input  logic signed [PORT_W-1:0] vertex1_y,
    input  logic signed [PORT_W-1:0] vertex1_z,
    input  logic signed [PORT_W-1:0] vertex2_x,
    input  logic signed [PORT_W-1:0] vertex2_y,
    input  logic signed [PORT_W-1:0] vertex2_z,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     status,
    output logic [ERR_W-1:0]         error_value
);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [U_W-1:0]         edge_t;
    typedef logic signed [N_W-1:0]         norm_t;
    typedef logic signed [M_W-1:0]         mono_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   eval_reg, eval_next;
    logic                   stat_reg, stat_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [COEF_W-1:0]      coef_reg [NCOEF];
    logic [COEF_W-1:0]      acc_reg, acc_next;

    coord_t                 p_reg [3];
    edge_t                  u_reg [3];
    edge_t                  w_reg [3];
    norm_t                  n_reg [3];
    logic signed [D_W-1:0]  d_reg;
    mono_t                  m_reg [6];

    logic                   wb_valid_reg;
    op_t                    wb_op_reg;
    coef_idx_t              wb_k_reg;

    logic                   result_valid_reg;
    logic                   status_reg;
    logic [ERR_W-1:0]       error_reg;

    logic                   accept;
    logic                   out_free;
    logic                   issue;
    logic [STEP_W-1:0]      seq_len;
    op_t                    iss_op;
    coef_idx_t              iss_k;
    coef_idx_t              rd_k;
    logic [COEF_W-1:0]      coef_rd;
    logic [COEF_W-1:0]      prod_ext;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [M_W:0]    emul;
    logic signed [PROD_W-1:0]  prod;
    coord_t                 c_in [9];

    // Coordinates taken as their low COORD_WIDTH bits
    assign c_in[0] = coord_t'(vertex0_x[COORD_WIDTH-1:0]);
    assign c_in[1] = coord_t'(vertex0_y[COORD_WIDTH-1:0]);
    assign c_in[2] = coord_t'(vertex0_z[COORD_WIDTH-1:0]);
    assign c_in[3] = coord_t'(vertex1_x[COORD_WIDTH-1:0]);
    assign c_in[4] = coord_t'(vertex1_y[COORD_WIDTH-1:0]);
    assign c_in[5] = coord_t'(vertex1_z[COORD_WIDTH-1:0]);
    assign c_in[6] = coord_t'(vertex2_x[COORD_WIDTH-1:0]);
    assign c_in[7] = coord_t'(vertex2_y[COORD_WIDTH-1:0]);
    assign c_in[8] = coord_t'(vertex2_z[COORD_WIDTH-1:0]);

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    // Step sequencing
    assign seq_len = eval_reg ? STEP_W'(EVAL_STEPS) : STEP_W'(ADD_STEPS);
    assign issue   = (state_reg == S_RUN) && (step_reg < seq_len);
    assign iss_op  = seq_op(eval_reg, step_reg);
    assign iss_k   = seq_coef(eval_reg, step_reg);

    // Store read port: issuing slot on evaluate, write-back slot on add
    assign rd_k     = eval_reg ? iss_k : wb_k_reg;
    assign coef_rd  = coef_reg[rd_k];
    assign prod_ext = COEF_W'(prod);

    // Point multiplier for the coefficient being evaluated
    always_comb
    begin
        case (iss_k)
            K_A2:    emul = (M_W+1)'(m_reg[0]);
            K_B2:    emul = (M_W+1)'(m_reg[1]);
            K_C2:    emul = (M_W+1)'(m_reg[2]);
            K_D2:    emul = (M_W+1)'(1);
            K_AB:    emul = $signed({m_reg[3], 1'b0});
            K_AC:    emul = $signed({m_reg[4], 1'b0});
            K_AD:    emul = (M_W+1)'($signed({p_reg[0], 1'b0}));
            K_BC:    emul = $signed({m_reg[5], 1'b0});
            K_BD:    emul = (M_W+1)'($signed({p_reg[1], 1'b0}));
            K_CD:    emul = (M_W+1)'($signed({p_reg[2], 1'b0}));
            default: emul = '0;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (iss_op)
            OP_UYWZ: begin op_a = MUL_A_W'(u_reg[1]); op_b = MUL_B_W'(w_reg[2]); end
            OP_UZWY: begin op_a = MUL_A_W'(u_reg[2]); op_b = MUL_B_W'(w_reg[1]); end
            OP_UZWX: begin op_a = MUL_A_W'(u_reg[2]); op_b = MUL_B_W'(w_reg[0]); end
            OP_UXWZ: begin op_a = MUL_A_W'(u_reg[0]); op_b = MUL_B_W'(w_reg[2]); end
            OP_UXWY: begin op_a = MUL_A_W'(u_reg[0]); op_b = MUL_B_W'(w_reg[1]); end
            OP_UYWX: begin op_a = MUL_A_W'(u_reg[1]); op_b = MUL_B_W'(w_reg[0]); end
            OP_DAX:  begin op_a = MUL_A_W'(n_reg[0]); op_b = MUL_B_W'(p_reg[0]); end
            OP_DBY:  begin op_a = MUL_A_W'(n_reg[1]); op_b = MUL_B_W'(p_reg[1]); end
            OP_DCZ:  begin op_a = MUL_A_W'(n_reg[2]); op_b = MUL_B_W'(p_reg[2]); end
            OP_QAA:  begin op_a = MUL_A_W'(n_reg[0]); op_b = MUL_B_W'(n_reg[0]); end
            OP_QBB:  begin op_a = MUL_A_W'(n_reg[1]); op_b = MUL_B_W'(n_reg[1]); end
            OP_QCC:  begin op_a = MUL_A_W'(n_reg[2]); op_b = MUL_B_W'(n_reg[2]); end
            OP_QAB:  begin op_a = MUL_A_W'(n_reg[0]); op_b = MUL_B_W'(n_reg[1]); end
            OP_QAC:  begin op_a = MUL_A_W'(n_reg[0]); op_b = MUL_B_W'(n_reg[2]); end
            OP_QBC:  begin op_a = MUL_A_W'(n_reg[1]); op_b = MUL_B_W'(n_reg[2]); end
            OP_QDD:  begin op_a = MUL_A_W'(d_reg);    op_b = MUL_B_W'(d_reg);    end
            OP_QAD:  begin op_a = MUL_A_W'(n_reg[0]); op_b = MUL_B_W'(d_reg);    end
            OP_QBD:  begin op_a = MUL_A_W'(n_reg[1]); op_b = MUL_B_W'(d_reg);    end
            OP_QCD:  begin op_a = MUL_A_W'(n_reg[2]); op_b = MUL_B_W'(d_reg);    end
            OP_MXX:  begin op_a = MUL_A_W'(p_reg[0]); op_b = MUL_B_W'(p_reg[0]); end
            OP_MYY:  begin op_a = MUL_A_W'(p_reg[1]); op_b = MUL_B_W'(p_reg[1]); end
            OP_MZZ:  begin op_a = MUL_A_W'(p_reg[2]); op_b = MUL_B_W'(p_reg[2]); end
            OP_MXY:  begin op_a = MUL_A_W'(p_reg[0]); op_b = MUL_B_W'(p_reg[1]); end
            OP_MXZ:  begin op_a = MUL_A_W'(p_reg[0]); op_b = MUL_B_W'(p_reg[2]); end
            OP_MYZ:  begin op_a = MUL_A_W'(p_reg[1]); op_b = MUL_B_W'(p_reg[2]); end
            OP_ELO:
            begin
                op_a = $signed({1'b0, coef_rd[HALF_W-1:0]});
                op_b = MUL_B_W'(emul);
            end
            OP_EHI:
            begin
                op_a = $signed({coef_rd[COEF_W-1], coef_rd[COEF_W-1:HALF_W]});
                op_b = MUL_B_W'(emul);
            end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    qea_mul u_mul (
        .clk  (clk),
        .en   (issue),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Control next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        eval_next  = eval_reg;
        stat_next  = stat_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    step_next  = '0;
                    eval_next  = 1'b0;
                    stat_next  = 1'b0;
                    state_next = S_DONE;
                    case (func)
                        FUNC_CLEAR: count_next = '0;
                        FUNC_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_TRIANGLES))
                            begin
                                stat_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        FUNC_EVAL:
                        begin
                            eval_next  = 1'b1;
                            state_next = S_RUN;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == seq_len)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            eval_reg     <= 1'b0;
            stat_reg     <= 1'b0;
            count_reg    <= '0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            eval_reg     <= eval_next;
            stat_reg     <= stat_next;
            count_reg    <= count_next;
            wb_valid_reg <= issue;
        end
    end

    // Write-back tag follows the product
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            wb_op_reg <= iss_op;
            wb_k_reg  <= iss_k;
        end
    end

    // Capture of the item's vertices
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= c_in[i];
                u_reg[i] <= edge_t'(c_in[i+3]) - edge_t'(c_in[i]);
                w_reg[i] <= edge_t'(c_in[i+6]) - edge_t'(c_in[i]);
            end
        end
    end

    // Normal, plane, monomial and evaluate accumulator write-back
    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = '0;
        end
        else if (wb_valid_reg && wb_op_reg == OP_ELO)
        begin
            acc_next = acc_reg + prod_ext;
        end
        else if (wb_valid_reg && wb_op_reg == OP_EHI)
        begin
            acc_next = acc_reg + {prod_ext[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (wb_valid_reg)
        begin
            case (wb_op_reg)
                OP_UYWZ: n_reg[0] <= norm_t'(prod);
                OP_UZWY: n_reg[0] <= n_reg[0] - norm_t'(prod);
                OP_UZWX: n_reg[1] <= norm_t'(prod);
                OP_UXWZ: n_reg[1] <= n_reg[1] - norm_t'(prod);
                OP_UXWY: n_reg[2] <= norm_t'(prod);
                OP_UYWX: n_reg[2] <= n_reg[2] - norm_t'(prod);
                OP_DAX:  d_reg    <= D_W'(0) - D_W'(prod);
                OP_DBY:  d_reg    <= d_reg - D_W'(prod);
                OP_DCZ:  d_reg    <= d_reg - D_W'(prod);
                OP_MXX:  m_reg[0] <= mono_t'(prod);
                OP_MYY:  m_reg[1] <= mono_t'(prod);
                OP_MZZ:  m_reg[2] <= mono_t'(prod);
                OP_MXY:  m_reg[3] <= mono_t'(prod);
                OP_MXZ:  m_reg[4] <= mono_t'(prod);
                OP_MYZ:  m_reg[5] <= mono_t'(prod);
                default: ;
            endcase
        end
    end

    // Coefficient store: cleared at once, accumulated one slot per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (accept && func == FUNC_CLEAR)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wb_valid_reg && !eval_reg && (wb_op_reg inside {[OP_QAA:OP_QCD]}))
        begin
            coef_reg[wb_k_reg] <= coef_rd + prod_ext;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            status_reg <= stat_reg;
            if (eval_reg && !acc_reg[COEF_W-1])
            begin
                error_reg <= acc_reg[ERR_W-1:0];
            end
            else
            begin
                error_reg <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign error_value  = error_reg;

    // Checks
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TRIANGLES))
        else $error("triangle count above limit");

    a_wb_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> state_reg == S_RUN)
        else $error("write-back outside of run");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (result_valid_reg && state_reg == S_IDLE))
        else $error("finished item not loaded into output register");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_CLEAR) |=> count_reg == '0)
        else $error("clear did not reset triangle count");

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for the quadric error accumulator: directed and random items
// against an exact-integer quadric predictor. Depends on qea_pkg and the top level.
`timescale 1ns / 1ps

module testbench
    import qea_pkg::*;
();

    localparam int STALL_MAX = 17;
    localparam int WATCHDOG  = 2000;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic             status;
        logic [ERR_W-1:0] error_value;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [FUNC_W-1:0] func = FUNC_CLEAR;
    logic signed [PORT_W-1:0] vertex0_x = '0, vertex0_y = '0, vertex0_z = '0;
    logic signed [PORT_W-1:0] vertex1_x = '0, vertex1_y = '0, vertex1_z = '0;
    logic signed [PORT_W-1:0] vertex2_x = '0, vertex2_y = '0, vertex2_z = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic status;
    logic [ERR_W-1:0] error_value;

    // Predictor state: ten quadric sums (a2 b2 c2 d2 ab ac ad bc bd cd) and count
    logic [63:0] quad_sum [NCOEF];
    int unsigned tri_count;
    outcome_t pending_q [$];
    int fail_count = 0;
    int result_count = 0;
    int idle_cycles = 0;
    int eval_nonzero = 0;
    int refused_adds = 0;

    quadric_error_accumulator_top dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] coord(input logic [PORT_W-1:0] v);
        return 64'(signed'(v[COORD_WIDTH-1:0]));
    endfunction

    // Apply one item to the predictor and return the expected outcome
    function automatic outcome_t predict_item(input logic [FUNC_W-1:0] f,
                                              input logic [PORT_W-1:0] v [9]);
        outcome_t o;
        logic [63:0] x0, y0, z0, ux, uy, uz, wx, wy, wz, a, b, c, d, r;
        o = '0;
        x0 = coord(v[0]); y0 = coord(v[1]); z0 = coord(v[2]);
        if (f == FUNC_CLEAR)
        begin
            foreach (quad_sum[i]) quad_sum[i] = '0;
            tri_count = 0;
        end
        else if (f == FUNC_ADD)
        begin
            if (tri_count >= MAX_TRIANGLES)
                o.status = 1'b1;
            else
            begin
                ux = coord(v[3]) - x0; uy = coord(v[4]) - y0; uz = coord(v[5]) - z0;
                wx = coord(v[6]) - x0; wy = coord(v[7]) - y0; wz = coord(v[8]) - z0;
                a = uy * wz - uz * wy;
                b = uz * wx - ux * wz;
                c = ux * wy - uy * wx;
                d = 64'd0 - (a * x0 + b * y0 + c * z0);
                quad_sum[K_A2] += a * a; quad_sum[K_B2] += b * b;
                quad_sum[K_C2] += c * c; quad_sum[K_D2] += d * d;
                quad_sum[K_AB] += a * b; quad_sum[K_AC] += a * c;
                quad_sum[K_AD] += a * d; quad_sum[K_BC] += b * c;
                quad_sum[K_BD] += b * d; quad_sum[K_CD] += c * d;
                tri_count++;
            end
        end
        else if (f == FUNC_EVAL)
        begin
            r = quad_sum[K_A2] * x0 * x0 + 2 * quad_sum[K_AB] * x0 * y0
              + 2 * quad_sum[K_AC] * x0 * z0 + 2 * quad_sum[K_AD] * x0
              + quad_sum[K_B2] * y0 * y0 + 2 * quad_sum[K_BC] * y0 * z0
              + 2 * quad_sum[K_BD] * y0 + quad_sum[K_C2] * z0 * z0
              + 2 * quad_sum[K_CD] * z0 + quad_sum[K_D2];
            if (!r[63])
                o.error_value = r[ERR_W-1:0];
        end
        return o;
    endfunction

    // Send one item after a random gap; returns once it is transferred
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PORT_W-1:0] v [9],
                             input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, STALL_MAX));
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func <= f;
        {vertex0_x, vertex0_y, vertex0_z} <= {v[0], v[1], v[2]};
        {vertex1_x, vertex1_y, vertex1_z} <= {v[3], v[4], v[5]};
        {vertex2_x, vertex2_y, vertex2_z} <= {v[6], v[7], v[8]};
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        pending_q.push_back(predict_item(f, v));
        @(negedge clk);
    endtask

    task automatic send_idle();
        item_valid <= 1'b0;
    endtask

    task automatic send_fill(input logic [FUNC_W-1:0] f, input logic signed [7:0] val);
        logic [PORT_W-1:0] v [9];
        foreach (v[i]) v[i] = val;
        send_item(f, v);
    endtask

    task automatic send_random(input logic [FUNC_W-1:0] f, input bit tiny = 0);
        logic [PORT_W-1:0] v [9];
        foreach (v[i]) v[i] = tiny ? PORT_W'($urandom_range(0, 6) - 3) : PORT_W'($urandom);
        send_item(f, v);
    endtask

    task automatic drain();
        send_idle();
        while (pending_q.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && result_valid && !result_stall)
        begin
            result_count++;
            if (pending_q.size() == 0)
            begin
                $error("result with no expectation waiting");
                fail_count++;
            end
            else
            begin
                exp_o = pending_q.pop_front();
                if (status !== exp_o.status)
                begin
                    $error("status expected %0d actual %0d", exp_o.status, status);
                    fail_count++;
                end
                if (error_value !== exp_o.error_value)
                begin
                    $error("error_value expected %0d actual %0d",
                           exp_o.error_value, error_value);
                    fail_count++;
                end
                if (exp_o.error_value != 0) eval_nonzero++;
                if (exp_o.status) refused_adds++;
            end
        end
    end

    // Receiver stall: random hold per transfer, sometimes none
    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
            result_stall <= (hold != 0);
            repeat (hold) @(negedge clk);
            result_stall <= 1'b0;
            @(negedge clk);
            while (!(result_valid)) @(negedge clk);
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Extremes of every coordinate, all function codes including the unused one
    task automatic test_directed();
        logic [PORT_W-1:0] v [9];
        send_fill(FUNC_EVAL, -8'sd128);        // empty store evaluates to zero
        send_fill(FUNC_ADD, 8'sd5);            // degenerate triangle still counted
        v = '{8'h80, 8'h7f, 8'h00, 8'h7f, 8'h80, 8'h7f, 8'h80, 8'h80, 8'h7f};
        send_item(FUNC_ADD, v);
        v = '{8'h7f, 8'h80, 8'h80, 8'h80, 8'h7f, 8'h80, 8'h7f, 8'h7f, 8'h80};
        send_item(FUNC_ADD, v);
        send_fill(FUNC_EVAL, 8'sd127);
        send_fill(FUNC_EVAL, -8'sd128);
        send_fill(FUNC_EVAL, 8'sd0);
        send_fill(FUNC_SPARE, -8'sd1);         // unused code
        send_fill(FUNC_EVAL, -8'sd1);
        send_fill(FUNC_CLEAR, -8'sd1);
        send_fill(FUNC_EVAL, 8'sd1);
    endtask

    // Fill the store past the limit so adds are refused
    task automatic test_full_store();
        send_fill(FUNC_CLEAR, 8'sd0);
        repeat (MAX_TRIANGLES + 3) send_random(FUNC_ADD);
        send_random(FUNC_EVAL);
        drain();                               // sender waits for all results
        send_random(FUNC_ADD);
        send_random(FUNC_EVAL);
    endtask

    // Random meshes: clear, a handful of adds and evaluates, some noise
    task automatic test_random_meshes();
        int sent;
        int n;
        bit tiny;
        sent = 0;
        while (sent < 1800)
        begin
            tiny = ($urandom_range(0, 4) == 0);
            send_random(FUNC_CLEAR);
            n = $urandom_range(1, MAX_TRIANGLES + 2);
            sent += 1 + n;
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: send_random(FUNC_EVAL, tiny);
                    3:       send_random(FUNC_SPARE);
                    default: send_random(FUNC_ADD, tiny);
                endcase
            end
        end
    endtask

    initial
    begin
        foreach (quad_sum[i]) quad_sum[i] = '0;
        tri_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_full_store();
        test_random_meshes();
        drain();
        $display("Covered clear, add, refused add, unused code and evaluate over %0d results;",
                 result_count);
        $display("%0d nonzero errors and %0d refused adds checked.", eval_nonzero,
                 refused_adds);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
